### rtl/ilt_pkg.sv
package ilt_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int LEVEL_W     = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int TAB_W       = 5;

  localparam logic [TAB_W-1:0] TAB_WIDTH_RESET = TAB_W'(8);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef enum logic [2:0] {
    KIND_NEWLINE = 3'd0,
    KIND_INDENT  = 3'd1,
    KIND_DEDENT  = 3'd2,
    KIND_EOF     = 3'd3,
    KIND_BYTE    = 3'd4
  } token_kind_t;

  typedef struct packed {
    logic [7:0] input_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    token_kind_t token_kind;
    logic [7:0]  byte_out;
    logic        stack_overflow;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage

### rtl/ilt_stack.sv
module ilt_stack (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ilt_pkg::stk_ctl_t            ctl,
  input  logic [ilt_pkg::LEVEL_W-1:0]  push_level,
  output logic [ilt_pkg::CNT_W-1:0]    count,
  output logic [ilt_pkg::LEVEL_W-1:0]  top,
  output logic                         full
);
  import ilt_pkg::*;

  logic [LEVEL_W-1:0] level_r [STACK_DEPTH];
  logic [CNT_W-1:0]   count_r;
  logic [PTR_W-1:0]   top_idx;
  logic [PTR_W-1:0]   wr_idx;

  assign top_idx = PTR_W'(count_r - CNT_W'(1));
  assign wr_idx  = count_r[PTR_W-1:0];
  assign full    = (count_r == CNT_W'(STACK_DEPTH));
  assign count   = count_r;
  assign top     = level_r[top_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= CNT_W'(1);
      level_r[0] <= '0;
    end else begin
      if (ctl.push && !full) begin
        level_r[wr_idx] <= push_level;
        count_r         <= count_r + CNT_W'(1);
      end else if (ctl.pop && count_r > CNT_W'(1)) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/indent_layout_tokenizer.sv
// An item is taken in the idle state and decoded in the next cycle. At line start, a first content
// byte gives a DEDENT per stack level above its column, or an INDENT if the column is deeper, and then
// the byte; a mid-line byte or newline gives one BYTE or NEWLINE token; end of input gives one DEDENT
// per level above the base, a NEWLINE and an EOF; other items give none. in_stall holds off the next
// item until the last result is written, and a stalled output register holds the flow. Reset (rst_n,
// synchronous) empties the indent stack to its base level, sets tab width to 8, starts at line start.
module indent_layout_tokenizer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ilt_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ilt_pkg::out_item_t          out_item,
  input  logic                        cfg_we,
  input  logic [ilt_pkg::TAB_W-1:0]   cfg_wdata
);
  import ilt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_PROC    = 9'b000000010,
    S_POP     = 9'b000000100,
    S_PUSH    = 9'b000001000,
    S_BYTE    = 9'b000010000,
    S_MIDNL   = 9'b000100000,
    S_EOI_POP = 9'b001000000,
    S_EOI_NL  = 9'b010000000,
    S_EOI_EOF = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  in_item_t           item_r;
  logic [LEVEL_W-1:0] column_r, column_nxt;
  logic               at_ls_r, at_ls_nxt;
  logic               in_comment_r, in_comment_nxt;
  logic               finished_r, finished_nxt;
  logic [TAB_W-1:0]   tab_width_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  stk_ctl_t           stk_ctl;
  logic [CNT_W-1:0]   stk_count;
  logic [LEVEL_W-1:0] stk_top;
  logic               stk_full;

  logic               out_free;
  logic [LEVEL_W:0]   col_sum;
  logic [7:0]         b;

  ilt_stack u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (stk_ctl),
    .push_level (column_r),
    .count      (stk_count),
    .top        (stk_top),
    .full       (stk_full)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign b         = item_r.input_byte;
  assign col_sum   = {1'b0, column_r}
                   + ((b == CH_SPACE) ? (LEVEL_W + 1)'(1) : (LEVEL_W + 1)'(tab_width_r));

  always_comb begin
    state_nxt      = state_r;
    column_nxt     = column_r;
    at_ls_nxt      = at_ls_r;
    in_comment_nxt = in_comment_r;
    finished_nxt   = finished_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_item_nxt   = out_item_r;
    stk_ctl        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PROC;
        end
      end
      S_PROC: begin
        state_nxt = S_IDLE;
        if (finished_r) begin
          state_nxt = S_IDLE;
        end else if (item_r.end_of_input) begin
          state_nxt      = S_EOI_POP;
          in_comment_nxt = 1'b0;
          column_nxt     = '0;
          at_ls_nxt      = 1'b1;
        end else if (in_comment_r) begin
          if (b == CH_LF) begin
            in_comment_nxt = 1'b0;
            column_nxt     = '0;
          end
        end else if (at_ls_r) begin
          if (b == CH_SPACE || b == CH_TAB) begin
            column_nxt = col_sum[LEVEL_W] ? '1 : col_sum[LEVEL_W-1:0];
          end else if (b inside {CH_CR, CH_FF}) begin
            column_nxt = column_r;
          end else if (b == CH_LF) begin
            column_nxt = '0;
          end else if (b == CH_HASH) begin
            in_comment_nxt = 1'b1;
          end else begin
            state_nxt = S_POP;
          end
        end else if (b == CH_LF) begin
          state_nxt = S_MIDNL;
        end else begin
          state_nxt = S_BYTE;
        end
      end
      S_POP: begin
        if (stk_count > CNT_W'(1) && column_r < stk_top) begin
          if (out_free) begin
            stk_ctl.pop   = 1'b1;
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{KIND_DEDENT, 8'h00, 1'b0, 1'b0};
          end
        end else if (column_r > stk_top) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_BYTE;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          stk_ctl.push  = 1'b1;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{KIND_INDENT, 8'h00, stk_full, 1'b0};
          state_nxt     = S_BYTE;
        end
      end
      S_BYTE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{KIND_BYTE, b, 1'b0, 1'b1};
          at_ls_nxt     = 1'b0;
          column_nxt    = '0;
          state_nxt     = S_IDLE;
        end
      end
      S_MIDNL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{KIND_NEWLINE, 8'h00, 1'b0, 1'b1};
          at_ls_nxt     = 1'b1;
          column_nxt    = '0;
          state_nxt     = S_IDLE;
        end
      end
      S_EOI_POP: begin
        if (stk_count > CNT_W'(1)) begin
          if (out_free) begin
            stk_ctl.pop   = 1'b1;
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{KIND_DEDENT, 8'h00, 1'b0, 1'b0};
          end
        end else begin
          state_nxt = S_EOI_NL;
        end
      end
      S_EOI_NL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{KIND_NEWLINE, 8'h00, 1'b0, 1'b0};
          state_nxt     = S_EOI_EOF;
        end
      end
      S_EOI_EOF: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{KIND_EOF, 8'h00, 1'b0, 1'b1};
          finished_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      column_r     <= '0;
      at_ls_r      <= 1'b1;
      in_comment_r <= 1'b0;
      finished_r   <= 1'b0;
      tab_width_r  <= TAB_WIDTH_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      column_r     <= column_nxt;
      at_ls_r      <= at_ls_nxt;
      in_comment_r <= in_comment_nxt;
      finished_r   <= finished_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        tab_width_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule
